// ===== hdl/geo_pkg.sv =====
package geo_pkg;

    // field widths
    localparam int GEO_LAT_W   = 40;
    localparam int GEO_LON_W   = 41;
    localparam int GEO_CHAR_W  = 7;
    localparam int GEO_IDX_W   = 4;
    localparam int GEO_COUNT_W = 4;

    // character count after reset
    localparam logic [GEO_COUNT_W-1:0] GEO_COUNT_RST = 4'd12;

    // bisection geometry: spans in whole degrees and integer bits they need
    localparam int GEO_LAT_SPAN_DEG = 180;
    localparam int GEO_LON_SPAN_DEG = 360;
    localparam int GEO_LAT_INT_W    = 8;
    localparam int GEO_LON_INT_W    = 9;

    localparam int GEO_BITS_PER_CHAR = 5;
    localparam int GEO_RADIX_BITS    = 3;

    // queue between front and back
    localparam int GEO_Q_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } geo_q_stat_t;

    // base-32 alphabet as ascii codes
    localparam logic [GEO_CHAR_W-1:0] GEO_ALPHABET [32] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

endpackage

// ===== hdl/geo_front.sv =====
module geo_front #(
    parameter int MAX_CHARS = 12,
    parameter int FRAC_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [geo_pkg::GEO_LAT_W-1:0]   lat_fixed,
    input  logic signed [geo_pkg::GEO_LON_W-1:0]   lon_fixed,
    input  logic                                   char_count_we,
    input  logic [geo_pkg::GEO_COUNT_W-1:0]        char_count_wdata,
    input  geo_pkg::geo_q_stat_t                   q_stat,
    output logic                                   busy,
    output logic                                   push,
    output logic [geo_pkg::GEO_COUNT_W + 2*FRAC_BITS
                  + geo_pkg::GEO_LAT_INT_W + geo_pkg::GEO_LON_INT_W - 1:0] entry
);
    import geo_pkg::*;

    localparam int LAT_RW = FRAC_BITS + GEO_LAT_INT_W;
    localparam int LON_RW = FRAC_BITS + GEO_LON_INT_W;
    localparam int LAT_UW = ((GEO_LAT_W > LAT_RW) ? GEO_LAT_W : LAT_RW) + 1;
    localparam int LON_UW = ((GEO_LON_W > LON_RW) ? GEO_LON_W : LON_RW) + 1;

    localparam logic signed [LAT_UW-1:0] LAT_SPAN = LAT_UW'(GEO_LAT_SPAN_DEG) << FRAC_BITS;
    localparam logic signed [LON_UW-1:0] LON_SPAN = LON_UW'(GEO_LON_SPAN_DEG) << FRAC_BITS;
    localparam logic signed [LAT_UW-1:0] LAT_OFF =
        LAT_UW'(GEO_LAT_SPAN_DEG / 2) << FRAC_BITS;
    localparam logic signed [LON_UW-1:0] LON_OFF =
        LON_UW'(GEO_LON_SPAN_DEG / 2) << FRAC_BITS;
    localparam logic [LAT_RW-1:0] LAT_TOP = LAT_RW'(LAT_SPAN - LAT_UW'(1));
    localparam logic [LON_RW-1:0] LON_TOP = LON_RW'(LON_SPAN - LON_UW'(1));

    logic [GEO_COUNT_W-1:0]    char_count_reg;
    logic [GEO_COUNT_W-1:0]    count;
    logic signed [LAT_UW-1:0]  lat_u;
    logic signed [LON_UW-1:0]  lon_u;
    logic [LAT_RW-1:0]         lat_rem;
    logic [LON_RW-1:0]         lon_rem;

    // character count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= GEO_COUNT_RST;
        end
        else if (char_count_we)
        begin
            char_count_reg <= char_count_wdata;
        end
    end

    // count clamped to one..MAX_CHARS
    always_comb
    begin
        if (char_count_reg == '0)
        begin
            count = GEO_COUNT_W'(1);
        end
        else if (char_count_reg > GEO_COUNT_W'(MAX_CHARS))
        begin
            count = GEO_COUNT_W'(MAX_CHARS);
        end
        else
        begin
            count = char_count_reg;
        end
    end

    // offset from lower bound, out-of-range values pinned to the nearest edge
    always_comb
    begin
        lat_u = LAT_UW'(lat_fixed) + LAT_OFF;
        lon_u = LON_UW'(lon_fixed) + LON_OFF;

        if (lat_u[LAT_UW-1])
        begin
            lat_rem = '0;
        end
        else if (lat_u >= LAT_SPAN)
        begin
            lat_rem = LAT_TOP;
        end
        else
        begin
            lat_rem = lat_u[LAT_RW-1:0];
        end

        if (lon_u[LON_UW-1])
        begin
            lon_rem = '0;
        end
        else if (lon_u >= LON_SPAN)
        begin
            lon_rem = LON_TOP;
        end
        else
        begin
            lon_rem = lon_u[LON_RW-1:0];
        end
    end

    // transfer into the queue
    assign busy  = q_stat.full;
    assign push  = start && !q_stat.full;
    assign entry = {count, lat_rem, lon_rem};

endmodule

// ===== hdl/geo_queue.sv =====
module geo_queue #(
    parameter int DW = 77
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DW-1:0]        wdata,
    input  logic                 pop,
    output logic [DW-1:0]        rdata,
    output geo_pkg::geo_q_stat_t stat
);
    import geo_pkg::*;

    localparam int PTR_W = (GEO_Q_DEPTH > 1) ? $clog2(GEO_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(GEO_Q_DEPTH + 1);

    logic [DW-1:0]    slot_reg [GEO_Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(GEO_Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== hdl/geo_radix8.sv =====
module geo_radix8 #(
    parameter int               RW    = 41,
    parameter int               STEPS = 10,
    parameter logic [RW-1:0]    BASE  = '0
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  step,
    input  logic [RW-1:0]                         init_rem,
    output logic [geo_pkg::GEO_RADIX_BITS*STEPS-1:0] bits
);
    import geo_pkg::*;

    localparam int R    = GEO_RADIX_BITS;
    localparam int NB   = R * STEPS;
    localparam int MULT = (1 << R) - 1;

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] th_reg [1:MULT];
    logic [RW:0]   diff [1:MULT];
    logic [R-1:0]  digit;
    logic [NB-1:0] bits_reg;

    // trial subtract of every multiple, keep the largest that fits
    always_comb
    begin
        digit    = '0;
        rem_next = rem_reg;
        for (int m = 1; m <= MULT; m++)
        begin
            diff[m] = {1'b0, rem_reg} - {1'b0, th_reg[m]};
            if (!diff[m][RW])
            begin
                digit    = R'(m);
                rem_next = diff[m][RW-1:0];
            end
        end
    end

    // remainder, thresholds and collected digits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= init_rem;
            bits_reg <= '0;
            for (int m = 1; m <= MULT; m++)
            begin
                th_reg[m] <= RW'(BASE * RW'(m));
            end
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            bits_reg <= NB'({bits_reg, digit});
            for (int m = 1; m <= MULT; m++)
            begin
                th_reg[m] <= th_reg[m] >> R;
            end
        end
    end

    assign bits = bits_reg;

endmodule

// ===== hdl/geo_back.sv =====
module geo_back #(
    parameter int MAX_CHARS = 12,
    parameter int FRAC_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [geo_pkg::GEO_COUNT_W + 2*FRAC_BITS
                  + geo_pkg::GEO_LAT_INT_W + geo_pkg::GEO_LON_INT_W - 1:0] head,
    input  geo_pkg::geo_q_stat_t                q_stat,
    output logic                                pop,
    output logic                                char_valid,
    output logic [geo_pkg::GEO_CHAR_W-1:0]      hash_char,
    output logic [geo_pkg::GEO_IDX_W-1:0]       char_index,
    output logic                                last_char
);
    import geo_pkg::*;

    localparam int LAT_RW = FRAC_BITS + GEO_LAT_INT_W;
    localparam int LON_RW = FRAC_BITS + GEO_LON_INT_W;
    localparam int SW     = GEO_BITS_PER_CHAR * MAX_CHARS;
    localparam int LB     = (SW + 1) / 2;
    localparam int AB     = SW / 2;
    localparam int STEPS  = (LB + GEO_RADIX_BITS - 1) / GEO_RADIX_BITS;
    localparam int NB     = GEO_RADIX_BITS * STEPS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [LAT_RW-1:0] LAT_BASE =
        (LAT_RW'(GEO_LAT_SPAN_DEG) << FRAC_BITS) >> GEO_RADIX_BITS;
    localparam logic [LON_RW-1:0] LON_BASE =
        (LON_RW'(GEO_LON_SPAN_DEG) << FRAC_BITS) >> GEO_RADIX_BITS;

    logic [GEO_COUNT_W-1:0] head_count;
    logic [LAT_RW-1:0]      head_lat;
    logic [LON_RW-1:0]      head_lon;
    logic [NB-1:0]          lat_bits;
    logic [NB-1:0]          lon_bits;

    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [GEO_COUNT_W-1:0] bcount_reg;
    logic                   last_step;

    logic                   emit_reg, emit_next;
    logic [GEO_IDX_W-1:0]   idx_reg, idx_next;
    logic [GEO_IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [SW-1:0]          stream_reg;
    logic [SW-1:0]          stream_load;
    logic                   emit_last;
    logic                   take;

    assign head_count = head[LAT_RW + LON_RW +: GEO_COUNT_W];
    assign head_lat   = head[LON_RW +: LAT_RW];
    assign head_lon   = head[LON_RW-1:0];

    // one digit unit per coordinate, run side by side
    geo_radix8 #(
        .RW    (LAT_RW),
        .STEPS (STEPS),
        .BASE  (LAT_BASE)
    ) u_lat (
        .clk      (clk),
        .load     (pop),
        .step     (run_reg),
        .init_rem (head_lat),
        .bits     (lat_bits)
    );

    geo_radix8 #(
        .RW    (LON_RW),
        .STEPS (STEPS),
        .BASE  (LON_BASE)
    ) u_lon (
        .clk      (clk),
        .load     (pop),
        .step     (run_reg),
        .init_rem (head_lon),
        .bits     (lon_bits)
    );

    // handoff between bisection and character output
    always_comb
    begin
        emit_last = emit_reg && (idx_reg == last_idx_reg);
        take      = done_reg && (!emit_reg || emit_last);
        pop       = !q_stat.empty && !run_reg && (!done_reg || take);
        last_step = run_reg && (step_reg == STEP_W'(STEPS - 1));
    end

    // bisection sequencer
    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        done_next = done_reg;
        if (pop)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                run_next = 1'b0;
            end
        end
        if (last_step)
        begin
            done_next = 1'b1;
        end
        else if (take)
        begin
            done_next = 1'b0;
        end
    end

    // output sequencer
    always_comb
    begin
        emit_next     = emit_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        if (take)
        begin
            emit_next     = 1'b1;
            idx_next      = '0;
            last_idx_next = GEO_IDX_W'(bcount_reg - GEO_COUNT_W'(1));
        end
        else if (emit_last)
        begin
            emit_next = 1'b0;
        end
        else if (emit_reg)
        begin
            idx_next = idx_reg + GEO_IDX_W'(1);
        end
    end

    // interleave coordinate bits, longitude first
    always_comb
    begin
        stream_load = '0;
        for (int i = 0; i < LB; i++)
        begin
            stream_load[SW-1-2*i] = lon_bits[NB-1-i];
        end
        for (int i = 0; i < AB; i++)
        begin
            stream_load[SW-2-2*i] = lat_bits[NB-1-i];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
            emit_reg     <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            run_reg      <= run_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
            emit_reg     <= emit_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bcount_reg <= head_count;
        end
        if (take)
        begin
            stream_reg <= stream_load;
        end
        else if (emit_reg)
        begin
            stream_reg <= stream_reg << GEO_BITS_PER_CHAR;
        end
    end

    assign char_valid = emit_reg;
    assign hash_char  = GEO_ALPHABET[stream_reg[SW-1 -: GEO_BITS_PER_CHAR]];
    assign char_index = idx_reg;
    assign last_char  = emit_last;

endmodule

// ===== hdl/geohash_encoder.sv =====
// Geohash encoder. A coordinate pair is transferred at a clock edge with start high and
// busy low; busy rises only while the two-entry input queue is full. The pair is then
// loaded into the digit units, which run its radix-8 bisection, and its characters
// follow on hash_char, one per cycle, each marked by char_valid for exactly one cycle,
// with last_char on the final one. The bisection of one pair overlaps the output of
// the one before, so the sustained rate is set by the larger of the bisection time and
// the character count per pair. The receiver cannot stall: every strobed character must
// be taken in its cycle. char_count is to be written only while the block is idle;
// the block itself does not enforce this.
module geohash_encoder #(
    parameter int MAX_CHARS = 12,
    parameter int FRAC_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [geo_pkg::GEO_LAT_W-1:0]   lat_fixed,
    input  logic signed [geo_pkg::GEO_LON_W-1:0]   lon_fixed,
    input  logic                                   char_count_we,
    input  logic [geo_pkg::GEO_COUNT_W-1:0]        char_count_wdata,
    output logic                                   char_valid,
    output logic [geo_pkg::GEO_CHAR_W-1:0]         hash_char,
    output logic [geo_pkg::GEO_IDX_W-1:0]          char_index,
    output logic                                   last_char
);
    import geo_pkg::*;

    localparam int DW = GEO_COUNT_W + 2*FRAC_BITS + GEO_LAT_INT_W + GEO_LON_INT_W;

    logic          push;
    logic          pop;
    logic [DW-1:0] entry;
    logic [DW-1:0] head;
    geo_q_stat_t   q_stat;

    // accept and classify
    geo_front #(
        .MAX_CHARS (MAX_CHARS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .lat_fixed        (lat_fixed),
        .lon_fixed        (lon_fixed),
        .char_count_we    (char_count_we),
        .char_count_wdata (char_count_wdata),
        .q_stat           (q_stat),
        .busy             (busy),
        .push             (push),
        .entry            (entry)
    );

    // decoupling queue
    geo_queue #(
        .DW (DW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .stat  (q_stat)
    );

    // bisection and character output
    geo_back #(
        .MAX_CHARS (MAX_CHARS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .char_valid (char_valid),
        .hash_char  (hash_char),
        .char_index (char_index),
        .last_char  (last_char)
    );

    // characters of one geohash come in consecutive cycles with rising index
    a_char_run: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !last_char |=>
            char_valid && (char_index == $past(char_index) + GEO_IDX_W'(1)))
        else $error("geohash character run broken");

    // the back end never pulls from an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // character index stays within the configured maximum
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_index < GEO_IDX_W'(MAX_CHARS)))
        else $error("character index out of range");

endmodule
